// ===== rtl/core/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared widths, codes and word types of the segment distance field.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int COORD_W    = 20;
    localparam int DIST_W     = 20;
    localparam int IDX_W      = 12;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int GRID_W     = 7;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    localparam logic [DIST_W-1:0] TOP_CODE = 20'hFFFFF;

    localparam logic [GRID_W-1:0]     RST_COLUMNS     = 7'd64;
    localparam logic [GRID_W-1:0]     RST_ROWS        = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RST_CELL_WIDTH  = 20'd256;
    localparam logic [CFG_DATA_W-1:0] RST_CELL_HEIGHT = 20'd256;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [IDX_W-1:0]   cell_index;
    } sdf_req_t;

    typedef struct packed {
        logic [DIST_W-1:0] cell_distance;
        logic [DIST_W-1:0] max_distance;
    } sdf_rsp_t;

endpackage

// ===== rtl/core/segment_distance_field.sv =====
// ----------------------------------------------------------------------------
// segment_distance_field
// Grid of cell distances to line segments, Q12.8, all ones is infinity.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   start, busy, req (sdf_req_t)        taken when start and !busy
//  result    done, rsp (sdf_rsp_t)               one cycle on done, no stall
//  config    cfg_write, cfg_index, cfg_data      written when cfg_write
//
//  One request at a time; a clear writes one store entry per cycle. An add
//  walks each cell in use: a far cell is only written; otherwise the
//  shared multiplier, then the one-bit-per-cycle divider when the
//  projection wins, then the root unit give its distance; when the nearer
//  endpoint wins the divider is skipped.
//  After reset the store is swept to infinity with busy high.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
module segment_distance_field
    import sdf_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sdf_req_t              req,
    output logic                  busy,
    output logic                  done,
    output sdf_rsp_t              rsp,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CCW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RCW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam int QW = 40;   // quotient and root operand width
    localparam logic [3:0] SETUP_LAST = 4'd2;
    localparam logic [3:0] MUL_LAST   = 4'd11;
    localparam logic [5:0] DIV_LAST   = 6'(QW - 1);
    localparam logic [5:0] SQRT_LAST  = 6'(QW / 2 - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_READ, S_READ_OUT, S_SETUP, S_CELL,
        S_MUL, S_DECIDE, S_DIV, S_SQRT, S_WRITE
    } state_t;

    // control
    state_t                state_reg;
    logic [AW-1:0]         addr_reg;
    logic [CCW-1:0]        col_reg;
    logic [RCW-1:0]        row_reg;
    logic [3:0]            mstep_reg;
    logic [5:0]            cnt_reg;
    logic                  report_reg;
    logic [DIST_W-1:0]     grid_max_reg;
    logic [DIST_W-1:0]     max_acc_reg;
    logic                  done_reg;
    sdf_rsp_t              rsp_reg;
    logic [GRID_W-1:0]     cols_reg;
    logic [GRID_W-1:0]     rows_reg;
    logic [CFG_DATA_W-1:0] cw_reg;
    logic [CFG_DATA_W-1:0] ch_reg;

    // datapath
    logic [20:0]        sx_reg, sy_reg, tx_reg, ty_reg;
    logic signed [21:0] ux_reg, uy_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [21:0]        px_reg, py_reg;
    logic               far_x_reg, far_y_reg;
    logic signed [24:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [49:0] prod_reg;
    logic signed [49:0] uu_reg, dot_reg, cr_reg, s0_reg, s1_reg;
    logic [87:0]        num_reg;
    logic [45:0]        den_reg;
    logic [45:0]        rem_reg;
    logic [QW-1:0]      nlo_reg;
    logic [QW-1:0]      op_reg, res_reg, one_reg;

    // store
    logic [DIST_W-1:0] store_mem [DEPTH];
    logic [DIST_W-1:0] rd_q;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [DIST_W-1:0] mem_wd;

    logic              accept;
    logic [GRID_W-1:0] cols_eff, rows_eff;
    logic              last_col, last_row;
    logic [31:0]       idx32;
    logic              idx_in_range;

    logic [20:0]        in_sx, in_sy, in_tx, in_ty;
    logic [23:0]        px_sum, py_sum;
    logic signed [24:0] mul_a, mul_b;
    logic signed [49:0] mul_p;
    logic [49:0]        cr_mag;
    logic               proj, div_sat;
    logic [45:0]        den_next;
    logic [49:0]        near_sq;
    logic [QW-1:0]      near_q;
    logic [46:0]        div_t;
    logic               div_ge;
    logic [QW:0]        sq_trial;
    logic               sq_ge;
    logic [DIST_W-1:0]  cell_new;
    logic [DIST_W-1:0]  max_new;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign rsp      = rsp_reg;

    assign cols_eff = (32'(cols_reg) > MAX_COLUMNS) ? GRID_W'(MAX_COLUMNS) : cols_reg;
    assign rows_eff = (32'(rows_reg) > MAX_ROWS) ? GRID_W'(MAX_ROWS) : rows_reg;
    assign last_col = (32'(col_reg) + 32'd1 == 32'(cols_eff));
    assign last_row = (32'(row_reg) + 32'd1 == 32'(rows_eff));

    assign idx32        = 32'(idx_reg);
    assign idx_in_range = (idx32 < DEPTH);

    // endpoints in half units
    assign in_sx = {req.start_x, 1'b0};
    assign in_sy = {req.start_y, 1'b0};
    assign in_tx = {req.end_x, 1'b0};
    assign in_ty = {req.end_y, 1'b0};

    assign px_sum = {2'b00, px_reg} + {3'b000, cw_reg, 1'b0};
    assign py_sum = {2'b00, py_reg} + {3'b000, ch_reg, 1'b0};

    assign cr_mag = cr_reg[49] ? 50'(-cr_reg) : 50'(cr_reg);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SETUP)
        begin
            mul_a = 25'(ux_reg);
            mul_b = 25'(ux_reg);
            if (mstep_reg == 4'd1)
            begin
                mul_a = 25'(uy_reg);
                mul_b = 25'(uy_reg);
            end
        end
        else if (state_reg == S_MUL)
        begin
            case (mstep_reg)
                4'd0:    begin mul_a = ax_reg; mul_b = 25'(ux_reg); end
                4'd1:    begin mul_a = ay_reg; mul_b = 25'(uy_reg); end
                4'd2:    begin mul_a = ax_reg; mul_b = 25'(uy_reg); end
                4'd3:    begin mul_a = ay_reg; mul_b = 25'(ux_reg); end
                4'd4:    begin mul_a = ax_reg; mul_b = ax_reg; end
                4'd5:    begin mul_a = ay_reg; mul_b = ay_reg; end
                4'd6:    begin mul_a = bx_reg; mul_b = bx_reg; end
                4'd7:    begin mul_a = by_reg; mul_b = by_reg; end
                4'd8:
                begin
                    mul_a = $signed({4'b0, cr_mag[43:23]});
                    mul_b = $signed({4'b0, cr_mag[43:23]});
                end
                4'd9:
                begin
                    mul_a = $signed({4'b0, cr_mag[43:23]});
                    mul_b = $signed({2'b0, cr_mag[22:0]});
                end
                4'd10:
                begin
                    mul_a = $signed({2'b0, cr_mag[22:0]});
                    mul_b = $signed({2'b0, cr_mag[22:0]});
                end
                default: ;
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // case selection and divider setup
    assign proj     = (uu_reg > 0) && (dot_reg >= 0) && (dot_reg <= uu_reg);
    assign den_next = {uu_reg[43:0], 2'b00};
    assign div_sat  = (num_reg[87:40] >= {2'b00, den_next});
    assign near_sq  = (s0_reg < s1_reg) ? 50'(s0_reg) : 50'(s1_reg);
    assign near_q   = (near_sq[49:42] != 8'd0) ? {QW{1'b1}} : near_sq[41:2];

    assign div_t  = {rem_reg, nlo_reg[QW-1]};
    assign div_ge = (div_t >= {1'b0, den_reg});

    assign sq_trial = {1'b0, res_reg} + {1'b0, one_reg};
    assign sq_ge    = ({1'b0, op_reg} >= sq_trial);

    assign cell_new = (res_reg[DIST_W-1:0] < rd_q) ? res_reg[DIST_W-1:0] : rd_q;
    assign max_new  = (cell_new > max_acc_reg) ? cell_new : max_acc_reg;

    // store ports
    assign rd_addr = (state_reg == S_READ) ? idx32[AW-1:0] : addr_reg;
    assign mem_we  = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign mem_wd  = (state_reg == S_CLEAR) ? TOP_CODE : cell_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[addr_reg] <= mem_wd;
        end
        rd_q <= store_mem[rd_addr];
    end

    // state machine and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            mstep_reg    <= '0;
            cnt_reg      <= '0;
            report_reg   <= 1'b0;
            grid_max_reg <= '0;
            max_acc_reg  <= '0;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
            cols_reg     <= RST_COLUMNS;
            rows_reg     <= RST_ROWS;
            cw_reg       <= RST_CELL_WIDTH;
            ch_reg       <= RST_CELL_HEIGHT;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_COLUMNS:     cols_reg <= cfg_data[GRID_W-1:0];
                    CFG_ROWS:        rows_reg <= cfg_data[GRID_W-1:0];
                    CFG_CELL_WIDTH:  cw_reg   <= cfg_data;
                    CFG_CELL_HEIGHT: ch_reg   <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req.req_type)
                            REQ_CLEAR:
                            begin
                                state_reg  <= S_CLEAR;
                                addr_reg   <= '0;
                                report_reg <= 1'b1;
                            end
                            REQ_ADD:
                            begin
                                if (cols_eff == '0 || rows_eff == '0)
                                begin
                                    grid_max_reg <= '0;
                                    done_reg     <= 1'b1;
                                    rsp_reg      <= '0;
                                end
                                else
                                begin
                                    state_reg   <= S_SETUP;
                                    mstep_reg   <= '0;
                                    addr_reg    <= '0;
                                    col_reg     <= '0;
                                    row_reg     <= '0;
                                    max_acc_reg <= '0;
                                end
                            end
                            REQ_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                                done_reg              <= 1'b1;
                                rsp_reg.cell_distance <= '0;
                                rsp_reg.max_distance  <= grid_max_reg;
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_reg == LAST_ADDR)
                    begin
                        state_reg  <= S_IDLE;
                        report_reg <= 1'b0;
                        if (report_reg)
                        begin
                            grid_max_reg <= (cols_eff != '0 && rows_eff != '0)
                                            ? TOP_CODE : '0;
                            done_reg              <= 1'b1;
                            rsp_reg.cell_distance <= '0;
                            rsp_reg.max_distance  <= (cols_eff != '0 && rows_eff != '0)
                                                     ? TOP_CODE : '0;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_READ_OUT;
                end
                S_READ_OUT:
                begin
                    state_reg             <= S_IDLE;
                    done_reg              <= 1'b1;
                    rsp_reg.cell_distance <= idx_in_range ? rd_q : TOP_CODE;
                    rsp_reg.max_distance  <= grid_max_reg;
                end
                S_SETUP:
                begin
                    mstep_reg <= mstep_reg + 4'd1;
                    if (mstep_reg == SETUP_LAST)
                    begin
                        state_reg <= S_CELL;
                    end
                end
                S_CELL:
                begin
                    mstep_reg <= '0;
                    state_reg <= (far_x_reg || far_y_reg) ? S_WRITE : S_MUL;
                end
                S_MUL:
                begin
                    mstep_reg <= mstep_reg + 4'd1;
                    if (mstep_reg == MUL_LAST)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (proj && !div_sat) ? S_DIV : S_SQRT;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == SQRT_LAST)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    max_acc_reg <= max_new;
                    addr_reg    <= addr_reg + AW'(1);
                    state_reg   <= S_CELL;
                    if (last_col)
                    begin
                        col_reg <= '0;
                        if (last_row)
                        begin
                            state_reg             <= S_IDLE;
                            grid_max_reg          <= max_new;
                            done_reg              <= 1'b1;
                            rsp_reg.cell_distance <= '0;
                            rsp_reg.max_distance  <= max_new;
                        end
                        else
                        begin
                            row_reg <= row_reg + RCW'(1);
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + CCW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // geometry datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sx_reg    <= in_sx;
                    sy_reg    <= in_sy;
                    tx_reg    <= in_tx;
                    ty_reg    <= in_ty;
                    ux_reg    <= $signed({1'b0, in_tx}) - $signed({1'b0, in_sx});
                    uy_reg    <= $signed({1'b0, in_ty}) - $signed({1'b0, in_sy});
                    idx_reg   <= req.cell_index;
                    px_reg    <= 22'(cw_reg);
                    py_reg    <= 22'(ch_reg);
                    far_x_reg <= 1'b0;
                    far_y_reg <= 1'b0;
                end
            end
            S_SETUP:
            begin
                if (mstep_reg == 4'd1)
                begin
                    uu_reg <= prod_reg;
                end
                else if (mstep_reg == SETUP_LAST)
                begin
                    uu_reg <= uu_reg + prod_reg;
                end
            end
            S_CELL:
            begin
                ax_reg  <= $signed({3'b0, px_reg}) - $signed({4'b0, sx_reg});
                ay_reg  <= $signed({3'b0, py_reg}) - $signed({4'b0, sy_reg});
                bx_reg  <= $signed({3'b0, px_reg}) - $signed({4'b0, tx_reg});
                by_reg  <= $signed({3'b0, py_reg}) - $signed({4'b0, ty_reg});
                res_reg <= QW'(TOP_CODE);
            end
            S_MUL:
            begin
                case (mstep_reg)
                    4'd1:    dot_reg <= prod_reg;
                    4'd2:    dot_reg <= dot_reg + prod_reg;
                    4'd3:    cr_reg  <= prod_reg;
                    4'd4:    cr_reg  <= cr_reg - prod_reg;
                    4'd5:    s0_reg  <= prod_reg;
                    4'd6:    s0_reg  <= s0_reg + prod_reg;
                    4'd7:    s1_reg  <= prod_reg;
                    4'd8:    s1_reg  <= s1_reg + prod_reg;
                    4'd9:    num_reg <= 88'(unsigned'(prod_reg)) << 46;
                    4'd10:   num_reg <= num_reg + (88'(unsigned'(prod_reg)) << 24);
                    4'd11:   num_reg <= num_reg + 88'(unsigned'(prod_reg));
                    default: ;
                endcase
            end
            S_DECIDE:
            begin
                den_reg <= den_next;
                rem_reg <= num_reg[85:40];
                nlo_reg <= num_reg[QW-1:0];
                res_reg <= '0;
                one_reg <= QW'(1) << (QW - 2);
                if (proj)
                begin
                    op_reg <= div_sat ? {QW{1'b1}} : '0;
                end
                else
                begin
                    op_reg <= near_q;
                end
            end
            S_DIV:
            begin
                // shift quotient bits into the root operand
                rem_reg <= div_ge ? 46'(div_t - {1'b0, den_reg}) : div_t[45:0];
                nlo_reg <= nlo_reg << 1;
                op_reg  <= {op_reg[QW-2:0], div_ge};
            end
            S_SQRT:
            begin
                if (sq_ge)
                begin
                    op_reg  <= QW'({1'b0, op_reg} - sq_trial);
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                one_reg <= one_reg >> 2;
            end
            S_WRITE:
            begin
                // step the cell centre, latch far once past the range
                if (last_col)
                begin
                    px_reg    <= 22'(cw_reg);
                    far_x_reg <= 1'b0;
                    if (!far_y_reg)
                    begin
                        if (py_sum[23:22] != 2'b00)
                        begin
                            far_y_reg <= 1'b1;
                        end
                        else
                        begin
                            py_reg <= py_sum[21:0];
                        end
                    end
                end
                else if (!far_x_reg)
                begin
                    if (px_sum[23:22] != 2'b00)
                    begin
                        far_x_reg <= 1'b1;
                    end
                    else
                    begin
                        px_reg <= px_sum[21:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word neither started nor answered");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_WRITE))
        else $error("store write outside clear or cell update");

    a_never_raise: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (mem_wd <= rd_q))
        else $error("cell update raised a stored distance");

endmodule
